FILE: hw/rtl/assert_macros.svh
// assertion macros used by the parser core
// no dependencies; include guard keeps a second include harmless
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication check, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed in multi-radix parser");

// same check, reported as a state invariant
`define ASSERT_STATE(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("state invariant violated in multi-radix parser");

`endif

FILE: hw/rtl/mbnp_pkg.sv
// shared types and ascii constants for the multi-radix number parser
// no dependencies
`timescale 1ns / 1ps

package mbnp_pkg;

  // ascii codes used by the character decoder
  localparam logic [7:0] ASCII_DIGIT_BASE  = 8'd48;
  localparam logic [7:0] ASCII_LETTER_BASE = 8'd55;
  localparam logic [7:0] ASCII_CASE_OFFSET = 8'd32;
  localparam logic [7:0] ASCII_PLUS        = 8'h2B;
  localparam logic [7:0] ASCII_MINUS       = 8'h2D;
  localparam logic [7:0] ASCII_ZERO        = 8'h30;
  localparam logic [7:0] ASCII_NINE        = 8'h39;
  localparam logic [7:0] ASCII_UPPER_A     = 8'h41;
  localparam logic [7:0] ASCII_UPPER_F     = 8'h46;
  localparam logic [7:0] ASCII_LOWER_A     = 8'h61;
  localparam logic [7:0] ASCII_LOWER_F     = 8'h66;

  // digit limits of the three smaller radices
  localparam logic [3:0] RADIX_BIN = 4'd2;
  localparam logic [3:0] RADIX_OCT = 4'd8;
  localparam logic [3:0] RADIX_DEC = 4'd10;

  // bit positions in the radix flag vector
  localparam int FLAG_BIN = 0;
  localparam int FLAG_OCT = 1;
  localparam int FLAG_DEC = 2;
  localparam int FLAG_HEX = 3;
  localparam int NUM_RADIX = 4;

  // decoded view of one character
  typedef struct packed {
    logic                 is_sign;
    logic                 is_minus;
    logic [NUM_RADIX-1:0] radix_ok;
    logic [3:0]           value;
  } digit_info_t;

endpackage

FILE: hw/rtl/mbnp_digit_decode.sv
// character decoder: sign detection and digit value per radix
// depends on mbnp_pkg
`timescale 1ns / 1ps

module mbnp_digit_decode (
  input  logic [7:0]           character,
  output mbnp_pkg::digit_info_t info
);
  import mbnp_pkg::*;

  logic       is_dec;
  logic       is_letter;
  logic [7:0] upper;
  logic [7:0] diff;

  // fold lower case letters onto upper case, then map to 0..15
  always_comb begin
    is_dec    = (character >= ASCII_ZERO) && (character <= ASCII_NINE);
    upper     = ((character >= ASCII_LOWER_A) && (character <= ASCII_LOWER_F)) ?
                (character - ASCII_CASE_OFFSET) : character;
    is_letter = (upper >= ASCII_UPPER_A) && (upper <= ASCII_UPPER_F);
    diff      = is_dec ? (character - ASCII_DIGIT_BASE) : (upper - ASCII_LETTER_BASE);

    info.value              = diff[3:0];
    info.is_sign            = (character == ASCII_PLUS) || (character == ASCII_MINUS);
    info.is_minus           = (character == ASCII_MINUS);
    info.radix_ok[FLAG_BIN] = is_dec && (diff[3:0] < RADIX_BIN);
    info.radix_ok[FLAG_OCT] = is_dec && (diff[3:0] < RADIX_OCT);
    info.radix_ok[FLAG_DEC] = is_dec && (diff[3:0] < RADIX_DEC);
    info.radix_ok[FLAG_HEX] = is_dec || is_letter;
  end

endmodule

FILE: hw/rtl/multi_base_number_parser_core.sv
// Multi-radix ASCII integer parser, top level.
// One character per transfer on the input channel (character, is_last); the
// last character of a string produces one result transfer on the output
// channel: four ok flags and four signed values in radix 2, 8, 10 and 16.
// A leading '+' or '-' sets the sign; values wrap to VALUE_WIDTH bits and
// read as zero when their ok flag is clear.
// Throughput: one character per cycle, set by the shift-and-add update of
// the four accumulators, while no full result register stalls the stage.
// Result path: the transfer of the last character loads the input register,
// and the update stage then loads the result register.
// When the receiver stalls, the result register holds its item; characters
// keep flowing until a second last character reaches the update stage, which
// then waits in the input register with in_ready low.
// Reset (rst, synchronous) empties both registers, clears the accumulators
// and sign, sets all ok flags and marks the next character as first.
// Depends on mbnp_pkg, mbnp_digit_decode and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_base_number_parser_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    character,
  input  logic                          is_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          binary_ok,
  output logic                          octal_ok,
  output logic                          decimal_ok,
  output logic                          hex_ok,
  output logic signed [VALUE_WIDTH-1:0] binary_value,
  output logic signed [VALUE_WIDTH-1:0] octal_value,
  output logic signed [VALUE_WIDTH-1:0] decimal_value,
  output logic signed [VALUE_WIDTH-1:0] hex_value
);
  import mbnp_pkg::*;

  // input register
  logic       in_reg_valid;
  logic [7:0] in_reg_char;
  logic       in_reg_last;

  // parse state
  logic [VALUE_WIDTH-1:0] bin_acc, oct_acc, dec_acc, hex_acc;
  logic [VALUE_WIDTH-1:0] bin_acc_next, oct_acc_next, dec_acc_next, hex_acc_next;
  logic [NUM_RADIX-1:0]   flags, flags_next;
  logic                   negative, negative_next;
  logic                   first, first_next;

  digit_info_t            info;
  logic                   stage_fire;
  logic [VALUE_WIDTH-1:0] digit_ext;
  logic [VALUE_WIDTH-1:0] signed_digit;

  // stage advances unless it would produce a result into a full, stalled register
  assign stage_fire = in_reg_valid && (!in_reg_last || !out_valid || out_ready);
  assign in_ready   = !in_reg_valid || stage_fire;

  // input register transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_reg_char <= character;
      in_reg_last <= is_last;
    end
  end

  mbnp_digit_decode u_decode (
    .character (in_reg_char),
    .info      (info)
  );

  // digits enter already signed, so the accumulators carry the final value
  assign digit_ext    = {{(VALUE_WIDTH-4){1'b0}}, info.value};
  assign signed_digit = negative ? ({VALUE_WIDTH{1'b0}} - digit_ext) : digit_ext;

  // accumulator and flag update
  always_comb begin
    bin_acc_next  = bin_acc;
    oct_acc_next  = oct_acc;
    dec_acc_next  = dec_acc;
    hex_acc_next  = hex_acc;
    flags_next    = flags;
    negative_next = negative;
    first_next    = 1'b0;
    if (first && info.is_sign) begin
      negative_next = info.is_minus;
    end else begin
      if (info.radix_ok[FLAG_BIN]) begin
        bin_acc_next = (bin_acc << 1) + signed_digit;
      end else begin
        flags_next[FLAG_BIN] = 1'b0;
      end
      if (info.radix_ok[FLAG_OCT]) begin
        oct_acc_next = (oct_acc << 3) + signed_digit;
      end else begin
        flags_next[FLAG_OCT] = 1'b0;
      end
      if (info.radix_ok[FLAG_DEC]) begin
        dec_acc_next = (dec_acc << 3) + (dec_acc << 1) + signed_digit;
      end else begin
        flags_next[FLAG_DEC] = 1'b0;
      end
      if (info.radix_ok[FLAG_HEX]) begin
        hex_acc_next = (hex_acc << 4) + signed_digit;
      end else begin
        flags_next[FLAG_HEX] = 1'b0;
      end
    end
  end

  // parse state registers, back to reset values after the last character
  always_ff @(posedge clk) begin
    if (rst || (stage_fire && in_reg_last)) begin
      bin_acc  <= '0;
      oct_acc  <= '0;
      dec_acc  <= '0;
      hex_acc  <= '0;
      flags    <= '1;
      negative <= 1'b0;
      first    <= 1'b1;
    end else if (stage_fire) begin
      bin_acc  <= bin_acc_next;
      oct_acc  <= oct_acc_next;
      dec_acc  <= dec_acc_next;
      hex_acc  <= hex_acc_next;
      flags    <= flags_next;
      negative <= negative_next;
      first    <= first_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_fire && in_reg_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (stage_fire && in_reg_last) begin
      binary_ok     <= flags_next[FLAG_BIN];
      octal_ok      <= flags_next[FLAG_OCT];
      decimal_ok    <= flags_next[FLAG_DEC];
      hex_ok        <= flags_next[FLAG_HEX];
      binary_value  <= flags_next[FLAG_BIN] ? bin_acc_next : '0;
      octal_value   <= flags_next[FLAG_OCT] ? oct_acc_next : '0;
      decimal_value <= flags_next[FLAG_DEC] ? dec_acc_next : '0;
      hex_value     <= flags_next[FLAG_HEX] ? hex_acc_next : '0;
    end
  end

  // assertions
  `ASSERT_CLK(a_stall_only_on_full_result, clk, rst,
    (in_reg_valid && !in_ready) |-> (in_reg_last && out_valid && !out_ready))
  `ASSERT_STATE(a_state_cleared_after_last, clk, rst,
    (stage_fire && in_reg_last) |=> (first && flags == '1 && !negative))
  `ASSERT_CLK(a_invalid_value_zero, clk, rst,
    out_valid |-> ((binary_ok || binary_value == '0) && (hex_ok || hex_value == '0)))
  `ASSERT_CLK(a_result_only_from_last, clk, rst,
    ($rose(out_valid)) |-> ($past(stage_fire) && $past(in_reg_last)))

endmodule

FILE: dv/mbnp_checker.sv
// scoreboard for the multi-radix number parser: watches both channels,
// predicts each result from accepted characters and compares field by field
// depends on mbnp_pkg
`timescale 1ns / 1ps

module mbnp_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [7:0]                    character,
  input  logic                          is_last,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          binary_ok,
  input  logic                          octal_ok,
  input  logic                          decimal_ok,
  input  logic                          hex_ok,
  input  logic signed [VALUE_WIDTH-1:0] binary_value,
  input  logic signed [VALUE_WIDTH-1:0] octal_value,
  input  logic signed [VALUE_WIDTH-1:0] decimal_value,
  input  logic signed [VALUE_WIDTH-1:0] hex_value,
  output int                            mismatches,
  output int                            results_pending
);

  import mbnp_pkg::*;

  // radix of each accumulator, indexed by flag position
  localparam int RADIX_OF [NUM_RADIX] = '{int'(RADIX_BIN), int'(RADIX_OCT),
                                          int'(RADIX_DEC), 16};

  typedef struct packed {
    logic [NUM_RADIX-1:0]                  ok;
    logic [NUM_RADIX-1:0][VALUE_WIDTH-1:0] value;
  } parsed_number_t;

  // predicted parser state
  logic [NUM_RADIX-1:0][VALUE_WIDTH-1:0] acc;
  logic [NUM_RADIX-1:0]                  radix_valid;
  logic                                  negative;
  logic                                  at_first;

  parsed_number_t parsed_q[$];
  int             error_total = 0;
  int             pending_total = 0;

  assign mismatches      = error_total;
  assign results_pending = pending_total;

  function automatic string radix_name(input int idx);
    case (idx)
      FLAG_BIN: return "binary";
      FLAG_OCT: return "octal";
      FLAG_DEC: return "decimal";
      default:  return "hex";
    endcase
  endfunction

  // digit value 0..15, or 16 for anything that is no hex digit
  function automatic int digit_value(input logic [7:0] ch);
    if (ch >= ASCII_ZERO && ch <= ASCII_NINE)
      return int'(ch) - int'(ASCII_DIGIT_BASE);
    if (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_F)
      return int'(ch) - int'(ASCII_LETTER_BASE);
    if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_F)
      return int'(ch) - int'(ASCII_CASE_OFFSET) - int'(ASCII_LETTER_BASE);
    return 16;
  endfunction

  task automatic clear_number();
    acc         = '0;
    radix_valid = '1;
    negative    = 1'b0;
    at_first    = 1'b1;
  endtask

  // one accepted character; the last one of a string queues a result
  task automatic take_character(input logic [7:0] ch, input logic last);
    int             d;
    parsed_number_t res;
    if (at_first && (ch == ASCII_PLUS || ch == ASCII_MINUS)) begin
      negative = (ch == ASCII_MINUS);
    end else begin
      d = digit_value(ch);
      for (int i = 0; i < NUM_RADIX; i++) begin
        if (d < RADIX_OF[i])
          acc[i] = acc[i] * VALUE_WIDTH'(RADIX_OF[i]) + VALUE_WIDTH'(d);
        else
          radix_valid[i] = 1'b0;
      end
    end
    at_first = 1'b0;
    if (last) begin
      res.ok = radix_valid;
      for (int i = 0; i < NUM_RADIX; i++) begin
        if (!radix_valid[i])
          res.value[i] = '0;
        else if (negative)
          res.value[i] = -acc[i];
        else
          res.value[i] = acc[i];
      end
      parsed_q.push_back(res);
      clear_number();
    end
  endtask

  task automatic check_field(input string field, input logic [VALUE_WIDTH-1:0] want,
                             input logic [VALUE_WIDTH-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      error_total++;
    end
  endtask

  // compare one result transfer against the oldest prediction
  task automatic check_result();
    parsed_number_t want;
    parsed_number_t got;
    if (parsed_q.size() == 0) begin
      $error("result transfer with no string pending");
      error_total++;
    end else begin
      want = parsed_q.pop_front();
      got.ok = {hex_ok, decimal_ok, octal_ok, binary_ok};
      got.value[FLAG_BIN] = binary_value;
      got.value[FLAG_OCT] = octal_value;
      got.value[FLAG_DEC] = decimal_value;
      got.value[FLAG_HEX] = hex_value;
      for (int i = 0; i < NUM_RADIX; i++) begin
        check_field({radix_name(i), "_ok"}, VALUE_WIDTH'(want.ok[i]),
                    VALUE_WIDTH'(got.ok[i]));
        check_field({radix_name(i), "_value"}, want.value[i], got.value[i]);
      end
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      clear_number();
      parsed_q.delete();
    end else begin
      if (out_valid && out_ready)
        check_result();
      if (in_valid && in_ready)
        take_character(character, is_last);
    end
    pending_total <= parsed_q.size();
  end

endmodule

FILE: dv/tb_top.sv
// top of the multi-radix number parser testbench: clock, reset, character
// stimulus, receiver stalls and the verdict
// depends on mbnp_pkg, mbnp_checker and multi_base_number_parser_core
`timescale 1ns / 1ps

module tb_top;

  import mbnp_pkg::*;

  localparam int W           = 32;
  localparam int NUM_CHARS   = 900;
  localparam int QUIET_AFTER = 760;
  localparam int CYCLE_LIMIT = 200000;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          character;
  logic                is_last;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                binary_ok, octal_ok, decimal_ok, hex_ok;
  logic signed [W-1:0] binary_value, octal_value, decimal_value, hex_value;

  int         mismatches;
  int         results_pending;
  int         chars_sent = 0;
  int         cycle_count = 0;
  int         ready_hold = 0;
  logic       quiet = 1'b0;
  logic [7:0] line_buf[$];

  // hand-picked strings: signs alone, single digits, mixed case, late sign,
  // and a negative hex value that wraps
  string directed_lines [9] = '{"-", "+", "0", "1", "-7", "+9", "aF", "1-",
                                "-FFFFFFFF9"};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multi_base_number_parser_core #(.VALUE_WIDTH(W)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .character(character), .is_last(is_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .binary_ok(binary_ok), .octal_ok(octal_ok),
    .decimal_ok(decimal_ok), .hex_ok(hex_ok),
    .binary_value(binary_value), .octal_value(octal_value),
    .decimal_value(decimal_value), .hex_value(hex_value)
  );

  mbnp_checker #(.VALUE_WIDTH(W)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .character(character), .is_last(is_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .binary_ok(binary_ok), .octal_ok(octal_ok),
    .decimal_ok(decimal_ok), .hex_ok(hex_ok),
    .binary_value(binary_value), .octal_value(octal_value),
    .decimal_value(decimal_value), .hex_value(hex_value),
    .mismatches(mismatches), .results_pending(results_pending)
  );

  // receiver: random bursts of ready and stall; once quiet, only ready bursts are started
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (quiet || $urandom_range(0, 2) != 0) begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(1, 30);
    end else begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(1, 19) - 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** multi_base_number_parser_core: FAILED **");
      $finish;
    end
  end

  task automatic load_text(input string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++)
      line_buf.push_back(s[i]);
  endtask

  // send line_buf as one string, with random gaps before characters unless quiet
  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      in_valid  <= 1'b1;
      character <= line_buf[i];
      is_last   <= (i == line_buf.size() - 1);
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      chars_sent++;
    end
  endtask

  // mostly well-formed numbers in one radix, some sign-only or late-sign
  // strings, and some noise near the digit set boundaries
  task automatic make_random_line();
    int kind;
    int radix;
    int len;
    int d;
    line_buf.delete();
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      case ($urandom_range(0, 3))
        0:       radix = 2;
        1:       radix = 8;
        2:       radix = 10;
        default: radix = 16;
      endcase
      case ($urandom_range(0, 2))
        1:       line_buf.push_back(ASCII_PLUS);
        2:       line_buf.push_back(ASCII_MINUS);
        default: ;
      endcase
      // long strings now and then to drive the accumulators past 32 bits
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 36) : $urandom_range(1, 10);
      repeat (len) begin
        d = $urandom_range(0, radix - 1);
        if (d < 10)
          line_buf.push_back(ASCII_ZERO + 8'(d));
        else if ($urandom_range(0, 1) == 1)
          line_buf.push_back(ASCII_LOWER_A + 8'(d - 10));
        else
          line_buf.push_back(ASCII_UPPER_A + 8'(d - 10));
      end
    end else if (kind == 7) begin
      line_buf.push_back($urandom_range(0, 1) ? ASCII_PLUS : ASCII_MINUS);
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 3))
          0:       line_buf.push_back(ASCII_PLUS);
          1:       line_buf.push_back(ASCII_MINUS);
          2:       line_buf.push_back(ASCII_ZERO + 8'($urandom_range(0, 9)));
          default: line_buf.push_back(ASCII_LOWER_A + 8'($urandom_range(0, 5)));
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 11))
          0:       line_buf.push_back(ASCII_ZERO - 8'd1);
          1:       line_buf.push_back(ASCII_NINE + 8'd1);
          2:       line_buf.push_back(ASCII_UPPER_A - 8'd1);
          3:       line_buf.push_back(ASCII_UPPER_F + 8'd1);
          4:       line_buf.push_back(ASCII_LOWER_A - 8'd1);
          5:       line_buf.push_back(ASCII_LOWER_F + 8'd1);
          default: line_buf.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    character = '0;
    is_last   = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed strings, then the all-ones and all-zeros bytes alone
    foreach (directed_lines[k]) begin
      load_text(directed_lines[k]);
      send_line();
    end
    line_buf.delete();
    line_buf.push_back(8'hFF);
    send_line();
    line_buf.delete();
    line_buf.push_back(8'h00);
    send_line();

    // random strings; idling stops for the tail of the run
    while (chars_sent < NUM_CHARS) begin
      if (chars_sent >= QUIET_AFTER)
        quiet <= 1'b1;
      make_random_line();
      send_line();
    end
    in_valid <= 1'b0;

    // drain the remaining results, then allow for the pipeline latency
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && results_pending == 0)
      $display("** multi_base_number_parser_core: PASSED **");
    else
      $display("** multi_base_number_parser_core: FAILED **");
    $finish;
  end

endmodule
